@@ rtl/tgq_pkg.sv @@
// Shared types, codes and default sizes for the team queue.
`default_nettype none

package tgq_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int ELEMENT_BITS_DEF = 10;
    localparam int NUM_TEAMS_DEF    = 16;
    localparam int CAPACITY_DEF     = 256;

    // Fixed widths of the command fields.
    localparam int FUNC_BITS    = 2;
    localparam int TEAM_ID_BITS = 4;

    // Function codes of an input item.
    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_ENQ  = 2'd1,
        FUNC_DEQ  = 2'd2
    } func_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Datapath operations, one per controller step.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_ENQ_RD1,
        OP_ENQ_RD2,
        OP_ENQ_WR,
        OP_DEQ_RD1,
        OP_DEQ_RD2,
        OP_DEQ_RD3,
        OP_DEQ_WR,
        OP_REJECT_FULL,
        OP_REJECT_EMPTY,
        OP_IGNORE
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        op_t  op;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic full;
        logic empty;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/tgq_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module tgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/tgq_ctrl.sv @@
// Controller state machine of the team queue: sequences each item through the datapath.
`default_nettype none

module tgq_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [tgq_pkg::FUNC_BITS-1:0]     func,
    input  wire tgq_pkg::stat_t                    stat,
    output tgq_pkg::cmd_t                          cmd,
    output logic                                   busy,
    output logic                                   done
);
    import tgq_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_ENQ_RD1,
        S_ENQ_RD2,
        S_ENQ_WR,
        S_DEQ_RD1,
        S_DEQ_RD2,
        S_DEQ_RD3,
        S_DEQ_WR,
        S_REJECT_FULL,
        S_REJECT_EMPTY,
        S_IGNORE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;
    logic   accept;

    assign accept = (state_reg == S_IDLE) && start;

    // Next state and the operation issued in the current state.
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.latch  = accept;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (func)
                        FUNC_LOAD: state_next = S_LOAD;
                        FUNC_ENQ:  state_next = stat.full ? S_REJECT_FULL : S_ENQ_RD1;
                        FUNC_DEQ:  state_next = stat.empty ? S_REJECT_EMPTY : S_DEQ_RD1;
                        default:   state_next = S_IGNORE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_ENQ_RD1:
            begin
                cmd.op     = OP_ENQ_RD1;
                state_next = S_ENQ_RD2;
            end
            S_ENQ_RD2:
            begin
                cmd.op     = OP_ENQ_RD2;
                state_next = S_ENQ_WR;
            end
            S_ENQ_WR:
            begin
                cmd.op     = OP_ENQ_WR;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_DEQ_RD1:
            begin
                cmd.op     = OP_DEQ_RD1;
                state_next = S_DEQ_RD2;
            end
            S_DEQ_RD2:
            begin
                cmd.op     = OP_DEQ_RD2;
                state_next = S_DEQ_RD3;
            end
            S_DEQ_RD3:
            begin
                cmd.op     = OP_DEQ_RD3;
                state_next = S_DEQ_WR;
            end
            S_DEQ_WR:
            begin
                cmd.op     = OP_DEQ_WR;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_REJECT_FULL:
            begin
                cmd.op     = OP_REJECT_FULL;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_REJECT_EMPTY:
            begin
                cmd.op     = OP_REJECT_EMPTY;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            S_IGNORE:
            begin
                cmd.op     = OP_IGNORE;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // A result strobe always lands in the idle state.
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    // No result appears while the mapping table is still being cleared.
    a_no_done_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !done)
        else $error("result during clearing pass");

endmodule

`default_nettype wire

@@ rtl/tgq_datapath.sv @@
// Datapath of the team queue: mapping, team, slot and order memories and their pointers.
`default_nettype none

module tgq_datapath #(
    parameter int ELEMENT_BITS = tgq_pkg::ELEMENT_BITS_DEF,
    parameter int NUM_TEAMS    = tgq_pkg::NUM_TEAMS_DEF,
    parameter int CAPACITY     = tgq_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tgq_pkg::cmd_t                       cmd,
    output tgq_pkg::stat_t                           stat,
    input  wire logic [ELEMENT_BITS-1:0]             element,
    input  wire logic [tgq_pkg::TEAM_ID_BITS-1:0]    team_id,
    output logic      [ELEMENT_BITS-1:0]             out_element,
    output logic                                     out_valid,
    output tgq_pkg::status_t                         status
);
    import tgq_pkg::*;

    localparam int EB         = ELEMENT_BITS;
    localparam int ELEM_COUNT = 1 << EB;
    localparam int TB         = $clog2(NUM_TEAMS);
    localparam int SB         = $clog2(CAPACITY);
    localparam int CB         = $clog2(CAPACITY + 1);
    localparam int CLR_DEPTH  = (ELEM_COUNT > NUM_TEAMS) ? ELEM_COUNT : NUM_TEAMS;
    localparam int KB         = $clog2(CLR_DEPTH);
    localparam int TRW        = 1 + 2 * SB;

    // Latched item and working registers.
    logic [EB-1:0] elem_reg;
    logic [TB-1:0] tid_reg;
    logic [TB-1:0] tid_mod;
    logic [SB-1:0] slot_reg;
    logic [SB-1:0] slot_next;
    logic [TB-1:0] team_reg;
    logic [TB-1:0] team_next;

    // Queue bookkeeping.
    logic [SB-1:0] free_head_reg;
    logic [SB-1:0] free_head_next;
    logic [CB-1:0] never_used_reg;
    logic [CB-1:0] never_used_next;
    logic [CB-1:0] used_reg;
    logic [CB-1:0] used_next;
    logic [TB-1:0] rd_ptr_reg;
    logic [TB-1:0] rd_ptr_next;
    logic [TB-1:0] wr_ptr_reg;
    logic [TB-1:0] wr_ptr_next;
    logic [KB-1:0] clr_cnt_reg;
    logic [KB-1:0] clr_cnt_next;

    // Result registers.
    logic [EB-1:0] out_element_reg;
    logic [EB-1:0] out_element_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    status_t       status_reg;
    status_t       status_next;

    // Memory ports.
    logic          map_we;
    logic [EB-1:0] map_waddr;
    logic [TB-1:0] map_wdata;
    logic          map_re;
    logic [TB-1:0] map_rdata;

    logic           team_we;
    logic [TB-1:0]  team_waddr;
    logic [TRW-1:0] team_wdata;
    logic           team_re;
    logic [TB-1:0]  team_raddr;
    logic [TRW-1:0] team_rdata;

    logic          sv_we;
    logic          sv_re;
    logic [EB-1:0] sv_rdata;

    logic          sn_we;
    logic [SB-1:0] sn_waddr;
    logic [SB-1:0] sn_wdata;
    logic          sn_re;
    logic [SB-1:0] sn_raddr;
    logic [SB-1:0] sn_rdata;

    logic          ord_we;
    logic          ord_re;
    logic [TB-1:0] ord_rdata;

    // Decoded team record and slot allocation.
    logic          team_busy;
    logic [SB-1:0] team_head;
    logic [SB-1:0] team_tail;
    logic          from_free;
    logic [SB-1:0] take_slot;
    logic          team_last;

    function automatic logic [TB-1:0] ptr_inc(input logic [TB-1:0] p);
        return (p == TB'(NUM_TEAMS - 1)) ? '0 : p + 1'b1;
    endfunction

    // Team number folded into range by repeated subtraction; at most seven steps.
    always_comb
    begin
        logic [TEAM_ID_BITS-1:0] v;
        v = team_id;
        for (int i = 0; i < 8; i++)
        begin
            if (int'(v) >= NUM_TEAMS)
            begin
                v = v - TEAM_ID_BITS'(NUM_TEAMS);
            end
        end
        tid_mod = TB'(v);
    end

    assign team_busy = team_rdata[TRW-1];
    assign team_head = team_rdata[2*SB-1:SB];
    assign team_tail = team_rdata[SB-1:0];
    assign team_last = (team_head == team_tail);

    // A freed slot is reused before a never used one.
    assign from_free = (never_used_reg > used_reg);
    assign take_slot = from_free ? free_head_reg : never_used_reg[SB-1:0];

    // Memory control and register updates for each operation.
    always_comb
    begin
        map_we           = 1'b0;
        map_waddr        = elem_reg;
        map_wdata        = tid_reg;
        map_re           = 1'b0;
        team_we          = 1'b0;
        team_waddr       = team_reg;
        team_wdata       = '0;
        team_re          = 1'b0;
        team_raddr       = map_rdata;
        sv_we            = 1'b0;
        sv_re            = 1'b0;
        sn_we            = 1'b0;
        sn_waddr         = team_tail;
        sn_wdata         = slot_reg;
        sn_re            = 1'b0;
        sn_raddr         = free_head_reg;
        ord_we           = 1'b0;
        ord_re           = 1'b0;
        slot_next        = slot_reg;
        team_next        = team_reg;
        free_head_next   = free_head_reg;
        never_used_next  = never_used_reg;
        used_next        = used_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        clr_cnt_next     = clr_cnt_reg;
        out_element_next = out_element_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        unique case (cmd.op)
            OP_CLEAR:
            begin
                // Zero one mapping entry and one team record per cycle.
                map_we       = ({1'b0, clr_cnt_reg} < (KB + 1)'(ELEM_COUNT));
                map_waddr    = clr_cnt_reg[EB-1:0];
                map_wdata    = '0;
                team_we      = ({1'b0, clr_cnt_reg} < (KB + 1)'(NUM_TEAMS));
                team_waddr   = clr_cnt_reg[TB-1:0];
                team_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            OP_LOAD:
            begin
                map_we           = 1'b1;
                out_element_next = '0;
                out_valid_next   = 1'b0;
                status_next      = ST_OK;
            end
            OP_ENQ_RD1:
            begin
                // Look up the team and the next free slot link.
                map_re   = 1'b1;
                sn_re    = 1'b1;
                sn_raddr = free_head_reg;
            end
            OP_ENQ_RD2:
            begin
                team_re    = 1'b1;
                team_raddr = map_rdata;
                team_next  = map_rdata;
                slot_next  = take_slot;
                used_next  = used_reg + 1'b1;
                if (from_free)
                begin
                    free_head_next = sn_rdata;
                end
                else
                begin
                    never_used_next = never_used_reg + 1'b1;
                end
            end
            OP_ENQ_WR:
            begin
                sv_we   = 1'b1;
                team_we = 1'b1;
                if (team_busy)
                begin
                    // Link behind the last queued member of the team.
                    sn_we      = 1'b1;
                    sn_waddr   = team_tail;
                    sn_wdata   = slot_reg;
                    team_wdata = {1'b1, team_head, slot_reg};
                end
                else
                begin
                    // New team group at the tail of the team order.
                    team_wdata  = {1'b1, slot_reg, slot_reg};
                    ord_we      = 1'b1;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                end
                out_element_next = '0;
                out_valid_next   = 1'b0;
                status_next      = ST_OK;
            end
            OP_DEQ_RD1:
            begin
                ord_re = 1'b1;
            end
            OP_DEQ_RD2:
            begin
                team_re    = 1'b1;
                team_raddr = ord_rdata;
                team_next  = ord_rdata;
            end
            OP_DEQ_RD3:
            begin
                sv_re     = 1'b1;
                sn_re     = 1'b1;
                sn_raddr  = team_head;
                slot_next = team_head;
            end
            OP_DEQ_WR:
            begin
                team_we = 1'b1;
                if (team_last)
                begin
                    team_wdata  = {1'b0, team_head, team_tail};
                    rd_ptr_next = ptr_inc(rd_ptr_reg);
                end
                else
                begin
                    team_wdata = {1'b1, sn_rdata, team_tail};
                end
                // Return the slot to the free list.
                sn_we            = 1'b1;
                sn_waddr         = slot_reg;
                sn_wdata         = free_head_reg;
                free_head_next   = slot_reg;
                used_next        = used_reg - 1'b1;
                out_element_next = sv_rdata;
                out_valid_next   = 1'b1;
                status_next      = ST_OK;
            end
            OP_REJECT_FULL:
            begin
                out_element_next = '0;
                out_valid_next   = 1'b0;
                status_next      = ST_FULL;
            end
            OP_REJECT_EMPTY:
            begin
                out_element_next = '0;
                out_valid_next   = 1'b0;
                status_next      = ST_EMPTY;
            end
            OP_IGNORE:
            begin
                out_element_next = '0;
                out_valid_next   = 1'b0;
                status_next      = ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg   <= '0;
            never_used_reg  <= '0;
            used_reg        <= '0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            clr_cnt_reg     <= '0;
            out_element_reg <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= ST_OK;
        end
        else
        begin
            free_head_reg   <= free_head_next;
            never_used_reg  <= never_used_next;
            used_reg        <= used_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_element_reg <= out_element_next;
            out_valid_reg   <= out_valid_next;
            status_reg      <= status_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            elem_reg <= element;
            tid_reg  <= tid_mod;
        end
        slot_reg <= slot_next;
        team_reg <= team_next;
    end

    tgq_ram #(.WIDTH(TB), .DEPTH(ELEM_COUNT)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (elem_reg),
        .rdata (map_rdata)
    );

    tgq_ram #(.WIDTH(TRW), .DEPTH(NUM_TEAMS)) u_team_ram (
        .clk   (clk),
        .we    (team_we),
        .waddr (team_waddr),
        .wdata (team_wdata),
        .re    (team_re),
        .raddr (team_raddr),
        .rdata (team_rdata)
    );

    tgq_ram #(.WIDTH(EB), .DEPTH(CAPACITY)) u_slot_value_ram (
        .clk   (clk),
        .we    (sv_we),
        .waddr (slot_reg),
        .wdata (elem_reg),
        .re    (sv_re),
        .raddr (team_head),
        .rdata (sv_rdata)
    );

    tgq_ram #(.WIDTH(SB), .DEPTH(CAPACITY)) u_slot_next_ram (
        .clk   (clk),
        .we    (sn_we),
        .waddr (sn_waddr),
        .wdata (sn_wdata),
        .re    (sn_re),
        .raddr (sn_raddr),
        .rdata (sn_rdata)
    );

    tgq_ram #(.WIDTH(TB), .DEPTH(NUM_TEAMS)) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (wr_ptr_reg),
        .wdata (team_reg),
        .re    (ord_re),
        .raddr (rd_ptr_reg),
        .rdata (ord_rdata)
    );

    assign stat.clear_done = (clr_cnt_reg == KB'(CLR_DEPTH - 1));
    assign stat.full       = (used_reg == CB'(CAPACITY));
    assign stat.empty      = (used_reg == '0);

    assign out_element = out_element_reg;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;

    // The occupancy never passes the slot count.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CB'(CAPACITY))
        else $error("slot occupancy beyond capacity");

    // Every occupied slot has been handed out at least once.
    a_never_used_ge: assert property (@(posedge clk) disable iff (!rst_n)
        never_used_reg >= used_reg)
        else $error("fresh slot pointer behind occupancy");

    // A delivered element always comes with an ok status.
    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_OK))
        else $error("valid element with error status");

    // A dequeue always frees exactly one slot.
    a_deq_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DEQ_WR) |=> (used_reg == $past(used_reg) - 1'b1))
        else $error("dequeue did not free one slot");

endmodule

`default_nettype wire

@@ rtl/team_grouped_queue.sv @@
// Top level of the team queue: controller and datapath.
`default_nettype none

// Team queue. An item is accepted at a rising edge where start is high and busy is
// low; func selects load-mapping (element -> team_id), enqueue of element, or
// dequeue. Every item gives exactly one result: out_element, out_valid and status
// stand on the ports for the single cycle in which done is high, and the receiver
// must take them then.
// Each item runs through the controller states in order: a load, a rejected item or
// an unknown func code goes straight to its result; an enqueue reads the mapping
// table and the free slot link, then the team record, then writes; a dequeue reads
// the team order, the team record, then the slot link and value, then writes back,
// each registered read feeding the next address. Busy drops together with done, so
// the next item can be accepted at the edge that takes the result.
// After reset the block clears the element-to-team table and the team records,
// one entry per cycle, until max(2**ELEMENT_BITS, NUM_TEAMS) entries (1024 with the
// default sizes) are cleared; busy is high throughout and no item is accepted.
// The slot memories and the team order memory need no clearing.
module team_grouped_queue #(
    parameter int ELEMENT_BITS = tgq_pkg::ELEMENT_BITS_DEF,
    parameter int NUM_TEAMS    = tgq_pkg::NUM_TEAMS_DEF,
    parameter int CAPACITY     = tgq_pkg::CAPACITY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [tgq_pkg::FUNC_BITS-1:0]       func,
    input  wire logic [ELEMENT_BITS-1:0]             element,
    input  wire logic [tgq_pkg::TEAM_ID_BITS-1:0]    team_id,
    output logic                                     done,
    output logic      [ELEMENT_BITS-1:0]             out_element,
    output logic                                     out_valid,
    output tgq_pkg::status_t                         status
);
    import tgq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    tgq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Memories and queue pointers.
    tgq_datapath #(
        .ELEMENT_BITS (ELEMENT_BITS),
        .NUM_TEAMS    (NUM_TEAMS),
        .CAPACITY     (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .element     (element),
        .team_id     (team_id),
        .out_element (out_element),
        .out_valid   (out_valid),
        .status      (status)
    );

endmodule

`default_nettype wire

@@ verif/team_grouped_queue_checker.sv @@
// Checker for the team queue: predicts every result and compares it with the block.
module team_grouped_queue_checker
    import tgq_pkg::*;
#(
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF,
    parameter int NUM_TEAMS    = NUM_TEAMS_DEF,
    parameter int CAPACITY     = CAPACITY_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [FUNC_BITS-1:0]    func,
    input  logic [ELEMENT_BITS-1:0] element,
    input  logic [TEAM_ID_BITS-1:0] team_id,
    input  logic                    done,
    input  logic [ELEMENT_BITS-1:0] out_element,
    input  logic                    out_valid,
    input  status_t                 status,
    output int                      mismatches,
    output int                      outstanding,
    output int                      full_rejects,
    output int                      empty_rejects
);

    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int TEAM_W    = (NUM_TEAMS > 1) ? $clog2(NUM_TEAMS) : 1;
    localparam int MAP_DEPTH = 1 << ELEMENT_BITS;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [ELEMENT_BITS-1:0] elem;
        logic                    valid;
        status_t                 st;
    } queue_result_t;

    // Predicted queue state: team mapping, linked slots, team groups and team order.
    logic [TEAM_W-1:0]       team_of      [MAP_DEPTH];
    logic [ELEMENT_BITS-1:0] slot_elem    [CAPACITY];
    logic [SLOT_W-1:0]       slot_link    [CAPACITY];
    logic [SLOT_W-1:0]       group_head   [NUM_TEAMS];
    logic [SLOT_W-1:0]       group_tail   [NUM_TEAMS];
    logic                    group_active [NUM_TEAMS];
    logic [TEAM_W-1:0]       team_order   [NUM_TEAMS];
    int                      order_rd;
    int                      order_wr;
    logic [SLOT_W-1:0]       free_top;
    logic [CNT_W-1:0]        fresh_next;
    logic [CNT_W-1:0]        occupancy;

    // Results still owed by the block, oldest first.
    queue_result_t dequeue_results [$];
    queue_result_t owed;
    queue_result_t predicted;

    initial
    begin
        mismatches    = 0;
        outstanding   = 0;
        full_rejects  = 0;
        empty_rejects = 0;
    end

    task automatic clear_queue_state();
        for (int i = 0; i < MAP_DEPTH; i++)
            team_of[i] = '0;
        for (int i = 0; i < NUM_TEAMS; i++)
            group_active[i] = 1'b0;
        order_rd   = 0;
        order_wr   = 0;
        free_top   = '0;
        fresh_next = '0;
        occupancy  = '0;
        dequeue_results.delete();
    endtask

    // Applies one item to the predicted queue and gives the result it should cause.
    task automatic apply_queue_op(
        input  logic [FUNC_BITS-1:0]    f,
        input  logic [ELEMENT_BITS-1:0] e,
        input  logic [TEAM_ID_BITS-1:0] t,
        output queue_result_t           r
    );
        logic [TEAM_W-1:0] grp;
        logic [SLOT_W-1:0] s;
        r    = '0;
        r.st = ST_OK;
        case (f)
            FUNC_LOAD:
                team_of[e] = TEAM_W'(t % NUM_TEAMS);
            FUNC_ENQ:
            begin
                if (occupancy >= CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    grp = team_of[e];
                    // Recycle a freed slot whenever there is one; hand out a never-used one only when none is free.
                    if (fresh_next > occupancy)
                    begin
                        s        = free_top;
                        free_top = slot_link[s];
                    end
                    else
                    begin
                        s          = SLOT_W'(fresh_next);
                        fresh_next = fresh_next + 1'b1;
                    end
                    occupancy    = occupancy + 1'b1;
                    slot_elem[s] = e;
                    if (!group_active[grp])
                    begin
                        group_active[grp]    = 1'b1;
                        group_head[grp]      = s;
                        group_tail[grp]      = s;
                        team_order[order_wr] = grp;
                        order_wr             = (order_wr + 1) % NUM_TEAMS;
                    end
                    else
                    begin
                        slot_link[group_tail[grp]] = s;
                        group_tail[grp]            = s;
                    end
                end
            end
            FUNC_DEQ:
            begin
                if (occupancy == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    grp     = team_order[order_rd];
                    s       = group_head[grp];
                    r.elem  = slot_elem[s];
                    r.valid = 1'b1;
                    // The team leaves the order when its last queued member goes.
                    if (s == group_tail[grp])
                    begin
                        group_active[grp] = 1'b0;
                        order_rd          = (order_rd + 1) % NUM_TEAMS;
                    end
                    else
                        group_head[grp] = slot_link[s];
                    slot_link[s] = free_top;
                    free_top     = s;
                    occupancy    = occupancy - 1'b1;
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic note_mismatch(input string what, input queue_result_t want);
        if (mismatches < REPORT_MAX)
        begin
            $display("%0t: %s: expected element %0d valid %0b status %0d,",
                     $time, what, want.elem, want.valid, want.st);
            $display("    got element %0d valid %0b status %0d",
                     out_element, out_valid, status);
        end
        mismatches++;
    endtask

    // Compare the result of this edge first, then predict the item accepted at it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_queue_state();
            outstanding = 0;
        end
        else
        begin
            if (done === 1'b1)
            begin
                if (dequeue_results.size() == 0)
                    note_mismatch("result with nothing owed", '0);
                else
                begin
                    owed = dequeue_results.pop_front();
                    if (out_element !== owed.elem || out_valid !== owed.valid
                        || status !== owed.st)
                        note_mismatch("result mismatch", owed);
                end
            end
            if (start && !busy)
            begin
                apply_queue_op(func, element, team_id, predicted);
                if (predicted.st == ST_FULL)
                    full_rejects++;
                if (predicted.st == ST_EMPTY)
                    empty_rejects++;
                dequeue_results.push_back(predicted);
            end
            outstanding = dequeue_results.size();
        end
    end

endmodule

@@ verif/team_grouped_queue_test.sv @@
// Testbench top for the team queue: clock, reset, item stimulus and verdict.
module team_grouped_queue_test;
    import tgq_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [ELEMENT_BITS_DEF-1:0] ELEM_MAX = '1;
    localparam logic [TEAM_ID_BITS-1:0]     TEAM_MAX = '1;
    localparam int PHASE_ITEMS  = 130;
    localparam int BURST_ITEMS  = 260;
    localparam logic [FUNC_BITS-1:0] FUNC_UNKNOWN = 2'd3;

    typedef enum {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN
    } traffic_mix_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [FUNC_BITS-1:0]        func;
    logic [ELEMENT_BITS_DEF-1:0] element;
    logic [TEAM_ID_BITS-1:0]     team_id;
    logic                        done;
    logic [ELEMENT_BITS_DEF-1:0] out_element;
    logic                        out_valid;
    status_t                     status;

    int mismatches;
    int outstanding;
    int full_rejects;
    int empty_rejects;
    int idle_pct;
    int cycle_count = 0;
    int n_load      = 0;
    int n_enq       = 0;
    int n_deq       = 0;
    int n_unknown   = 0;

    team_grouped_queue u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .element     (element),
        .team_id     (team_id),
        .done        (done),
        .out_element (out_element),
        .out_valid   (out_valid),
        .status      (status)
    );

    team_grouped_queue_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .element       (element),
        .team_id       (team_id),
        .done          (done),
        .out_element   (out_element),
        .out_valid     (out_valid),
        .status        (status),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .full_rejects  (full_rejects),
        .empty_rejects (empty_rejects)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("team_grouped_queue_test: done, errors");
            $finish;
        end
    end

    // Any element in the full range.
    function automatic logic [ELEMENT_BITS_DEF-1:0] any_element();
        return ELEMENT_BITS_DEF'($urandom_range(int'(ELEM_MAX)));
    endfunction

    // Any team number that the field can carry.
    function automatic logic [TEAM_ID_BITS-1:0] any_team();
        return TEAM_ID_BITS'($urandom_range(int'(TEAM_MAX)));
    endfunction

    // Mostly a small pool of elements so that mapped teams recur, sometimes the extremes.
    function automatic logic [ELEMENT_BITS_DEF-1:0] pick_element();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return ELEMENT_BITS_DEF'($urandom_range(31));
        else if (roll < 70)
            return $urandom_range(1) ? ELEM_MAX : '0;
        else
            return any_element();
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(
        input logic [FUNC_BITS-1:0]        f,
        input logic [ELEMENT_BITS_DEF-1:0] e,
        input logic [TEAM_ID_BITS-1:0]     t
    );
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        func    <= f;
        element <= e;
        team_id <= t;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        case (f)
            FUNC_LOAD: n_load++;
            FUNC_ENQ:  n_enq++;
            FUNC_DEQ:  n_deq++;
            default:   n_unknown++;
        endcase
        @(negedge clk);
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic send_random_item(input traffic_mix_t mix);
        int roll;
        int load_pct;
        int enq_pct;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:
            begin
                load_pct = 10;
                enq_pct  = 75;
            end
            MIX_DRAIN:
            begin
                load_pct = 5;
                enq_pct  = 20;
            end
            default:
            begin
                load_pct = 15;
                enq_pct  = 45;
            end
        endcase
        if (roll < load_pct)
            send_item(FUNC_LOAD, pick_element(), any_team());
        else if (roll < load_pct + enq_pct)
            send_item(FUNC_ENQ, pick_element(), any_team());
        else if (roll < 97)
            send_item(FUNC_DEQ, any_element(), any_team());
        else
            send_item(FUNC_UNKNOWN, any_element(), any_team());
    endtask

    // Segments of fill, drain or balanced traffic; ignored codes do not count.
    task automatic run_random_phase(input int item_target);
        int           base;
        int           seg_left;
        traffic_mix_t mix;
        base     = n_load + n_enq + n_deq;
        seg_left = 0;
        mix      = MIX_BALANCED;
        while (n_load + n_enq + n_deq - base < item_target)
        begin
            if (seg_left == 0)
            begin
                mix      = traffic_mix_t'($urandom_range(2));
                seg_left = $urandom_range(40, 10);
            end
            send_random_item(mix);
            seg_left--;
        end
    endtask

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        start    = 1'b0;
        func     = FUNC_LOAD;
        element  = '0;
        team_id  = '0;
        idle_pct = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty queue, team grouping, remapping a queued element, unknown code.
        send_item(FUNC_DEQ, 0, 0);
        send_item(FUNC_LOAD, ELEM_MAX, TEAM_MAX);
        send_item(FUNC_LOAD, 512, 8);
        send_item(FUNC_LOAD, 5, 3);
        send_item(FUNC_ENQ, ELEM_MAX, 0);
        send_item(FUNC_ENQ, 0, TEAM_MAX);
        send_item(FUNC_ENQ, 7, 0);
        send_item(FUNC_ENQ, 5, 0);
        send_item(FUNC_ENQ, ELEM_MAX, 0);
        send_item(FUNC_LOAD, ELEM_MAX, 1);
        send_item(FUNC_ENQ, ELEM_MAX, 0);
        send_item(FUNC_UNKNOWN, ELEM_MAX, TEAM_MAX);
        send_item(FUNC_DEQ, 0, 0);
        send_item(FUNC_DEQ, ELEM_MAX, TEAM_MAX);
        send_item(FUNC_DEQ, 0, 0);
        send_item(FUNC_ENQ, 0, 0);
        repeat (5) send_item(FUNC_DEQ, 0, 0);
        send_item(FUNC_DEQ, 0, 0);
        send_item(FUNC_ENQ, 512, 0);
        send_item(FUNC_DEQ, 0, 0);
        wait_for_results();

        // Random traffic with the sender idling now and then, then most of the time.
        idle_pct = 30;
        run_random_phase(PHASE_ITEMS);
        wait_for_results();
        idle_pct = 87;
        run_random_phase(PHASE_ITEMS);
        wait_for_results();

        // Back to back: fill past capacity, drain past empty, then mixed traffic.
        idle_pct = 0;
        repeat (BURST_ITEMS) send_item(FUNC_ENQ, pick_element(), any_team());
        wait_for_results();
        repeat (BURST_ITEMS) send_item(FUNC_DEQ, any_element(), 0);
        run_random_phase(PHASE_ITEMS);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d loads, %0d enqueues, %0d dequeues and %0d unknown codes,",
                 n_load, n_enq, n_deq, n_unknown);
        $display("with %0d full-queue and %0d empty-queue rejects at three sender idle rates.",
                 full_rejects, empty_rejects);
        if (mismatches == 0 && outstanding == 0)
            $display("team_grouped_queue_test: done, clean");
        else
            $display("team_grouped_queue_test: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/tgq_pkg.sv
rtl/tgq_ram.sv
rtl/tgq_ctrl.sv
rtl/tgq_datapath.sv
rtl/team_grouped_queue.sv
verif/team_grouped_queue_checker.sv
verif/team_grouped_queue_test.sv
